// File: sv/b64le_pkg.sv
// ----------------------------------------------------------------------------
// b64le_pkg
// Shared types, constants and the base64 symbol function for the line encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64le_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [9:0] LINE_LEN_RST = 10'd76;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_PAD = 8'h3D;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  // One unit of work for the back end: an optional line break, an optional
  // block of four characters and an optional terminator, or an error beat.
  typedef struct packed {
    logic       err;
    logic       brk;
    logic       blk;
    logic       term;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] len;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_CR,
    ST_LF,
    ST_C0,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_NUL
  } step_t;

  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] c;
    begin
      if (idx < 6'd26) begin
        c = 8'd65 + {2'b00, idx};
      end else if (idx < 6'd52) begin
        c = 8'd71 + {2'b00, idx};
      end else if (idx < 6'd62) begin
        c = {2'b00, idx} - 8'd4;
      end else if (idx == 6'd62) begin
        c = 8'd43;
      end else begin
        c = 8'd47;
      end
      return c;
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/base64_line_encoder_top.sv
// ----------------------------------------------------------------------------
// base64_line_encoder_top
// Streaming base64 encoder with optional CR LF line breaks.
//
//   Channel  Direction  Payload
//   in_*     input      tdata byte, tuser no_byte, tlast message end
//   out_*    output     tdata character, tuser config error, tlast last of beat
//   cfg_*    input      wdata line size, written when wen is high
//
// Each input beat is accepted while the job queue has room.
// The back end sends one character per cycle while the output is ready:
// four per group of three bytes, two per line break, one per terminator.
// Reset is synchronous and active low; line size resets to 76.
// Input and output stall independently through the four-entry job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_line_encoder_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wen,
  input  wire logic [9:0] cfg_wdata,  // [9:0] line length
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tuser,   // [0] no_byte
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] char_out
  output logic            out_tlast,
  output logic            out_tuser   // [0] config_error
);
  import b64le_pkg::*;

  logic [9:0] line_len_r;
  logic       q_full;
  logic       q_push;
  logic       q_valid;
  logic       q_pop;
  job_t       push_job;
  job_t       head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r <= LINE_LEN_RST;
    end else if (cfg_wen) begin
      line_len_r <= cfg_wdata;
    end
  end

  b64le_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .line_len_i  (line_len_r),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (push_job)
  );

  b64le_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_job)
  );

  b64le_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid_i  (q_valid),
    .q_job_i    (head_job),
    .q_pop_o    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// File: sv/b64le_front.sv
// ----------------------------------------------------------------------------
// b64le_front
// Accepts beats, groups bytes in threes and queues a job for each beat that
// ends a group or message or sees a bad line size; tracks lines per message.
// ----------------------------------------------------------------------------
`default_nettype none

module b64le_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [9:0]     line_len_i,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [7:0]     in_tdata,   // [7:0] data_byte
  input  wire logic           in_tuser,   // [0] no_byte
  input  wire logic           in_tlast,   // message_end
  input  wire logic           q_full_i,
  output logic                q_push_o,
  output b64le_pkg::job_t     q_job_o
);
  import b64le_pkg::*;

  logic [15:0] held_r, held_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic [7:0]  bil_r, bil_nxt;
  logic        first_r, first_nxt;

  logic        accept;
  logic        err;
  logic        take;
  logic        full;
  logic [15:0] held_aft;
  logic [1:0]  fill_aft;
  logic [7:0]  per_line;
  logic [7:0]  bil_base;
  job_t        job;

  assign in_tready = !q_full_i;
  assign accept    = in_tvalid && in_tready;
  assign err       = (line_len_i != 10'd0) && (line_len_i < 10'd4);
  assign per_line  = line_len_i[9:2];
  assign take      = !in_tuser;

  always_comb begin
    full     = 1'b0;
    held_aft = held_r;
    fill_aft = fill_r;
    if (take) begin
      case (fill_r)
        2'd0: begin
          held_aft = {in_tdata, 8'h00};
          fill_aft = 2'd1;
        end
        2'd1: begin
          held_aft = {held_r[15:8], in_tdata};
          fill_aft = 2'd2;
        end
        default: begin
          full     = 1'b1;
          held_aft = 16'h0000;
          fill_aft = 2'd0;
        end
      endcase
    end

    job      = '0;
    job.err  = err;
    job.term = in_tlast;
    if (full) begin
      job.blk = 1'b1;
      job.b0  = held_r[15:8];
      job.b1  = held_r[7:0];
      job.b2  = in_tdata;
      job.len = 2'd3;
    end else if (in_tlast && (fill_aft != 2'd0)) begin
      job.blk = 1'b1;
      job.b0  = held_aft[15:8];
      job.b1  = (fill_aft == 2'd2) ? held_aft[7:0] : 8'h00;
      job.b2  = 8'h00;
      job.len = fill_aft;
    end
    job.brk = job.blk && (per_line != 8'd0) && first_r && (bil_r >= per_line);

    bil_base = job.brk ? 8'd0 : bil_r;

    held_nxt  = held_r;
    fill_nxt  = fill_r;
    bil_nxt   = bil_r;
    first_nxt = first_r;
    if (accept && !err) begin
      if (in_tlast) begin
        held_nxt  = 16'h0000;
        fill_nxt  = 2'd0;
        bil_nxt   = 8'd0;
        first_nxt = 1'b0;
      end else begin
        held_nxt = held_aft;
        fill_nxt = fill_aft;
        if (full) begin
          first_nxt = 1'b1;
          bil_nxt   = (bil_base == 8'hFF) ? 8'hFF : bil_base + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 16'h0000;
      fill_r  <= 2'd0;
      bil_r   <= 8'd0;
      first_r <= 1'b0;
    end else begin
      held_r  <= held_nxt;
      fill_r  <= fill_nxt;
      bil_r   <= bil_nxt;
      first_r <= first_nxt;
    end
  end

  assign q_push_o = accept && (job.err || job.blk || job.term);
  assign q_job_o  = job;

endmodule

`default_nettype wire

// File: sv/b64le_queue.sv
// ----------------------------------------------------------------------------
// b64le_queue
// Small job queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module b64le_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_i,
  input  wire b64le_pkg::job_t push_job_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output b64le_pkg::job_t      head_o
);
  import b64le_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_r != '0);
  assign head_o  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push_i ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop_i ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_r] <= push_job_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full_o |-> !push_i)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_o |-> !pop_i)
    else $error("job popped from an empty queue");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push_i && !pop_i) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not follow a push");

endmodule

`default_nettype wire

// File: sv/b64le_back.sv
// ----------------------------------------------------------------------------
// b64le_back
// Steps each job into the output register, one char per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module b64le_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid_i,
  input  wire b64le_pkg::job_t q_job_i,
  output logic                 q_pop_o,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [7:0]           out_tdata,  // [7:0] char_out
  output logic                 out_tlast,  // run_last
  output logic                 out_tuser   // [0] config_error
);
  import b64le_pkg::*;

  step_t      step_r, step_nxt;
  step_t      after;
  step_t      start;
  job_t       cur_r;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r;
  logic       out_last_r;
  logic       out_err_r;

  logic       load_out;
  logic       emit;
  logic       take;
  logic       is_last;
  logic [7:0] chr;

  assign load_out = !out_valid_r || out_tready;
  assign emit     = (step_r != ST_IDLE) && load_out;

  always_comb begin
    chr     = CHAR_NUL;
    after   = ST_IDLE;
    is_last = 1'b1;
    case (step_r)
      ST_ERR: begin
        chr = CHAR_NUL;
      end
      ST_CR: begin
        chr     = CHAR_CR;
        after   = ST_LF;
        is_last = 1'b0;
      end
      ST_LF: begin
        chr     = CHAR_LF;
        after   = ST_C0;
        is_last = 1'b0;
      end
      ST_C0: begin
        chr     = b64_char(cur_r.b0[7:2]);
        after   = ST_C1;
        is_last = 1'b0;
      end
      ST_C1: begin
        chr     = b64_char({cur_r.b0[1:0], cur_r.b1[7:4]});
        after   = ST_C2;
        is_last = 1'b0;
      end
      ST_C2: begin
        chr     = (cur_r.len > 2'd1) ? b64_char({cur_r.b1[3:0], cur_r.b2[7:6]})
                                     : CHAR_PAD;
        after   = ST_C3;
        is_last = 1'b0;
      end
      ST_C3: begin
        chr     = (cur_r.len > 2'd2) ? b64_char(cur_r.b2[5:0]) : CHAR_PAD;
        after   = cur_r.term ? ST_NUL : ST_IDLE;
        is_last = !cur_r.term;
      end
      ST_NUL: begin
        chr = CHAR_NUL;
      end
      default: begin
        chr = CHAR_NUL;
      end
    endcase

    if (q_job_i.err) begin
      start = ST_ERR;
    end else if (q_job_i.brk) begin
      start = ST_CR;
    end else if (q_job_i.blk) begin
      start = ST_C0;
    end else begin
      start = ST_NUL;
    end

    take = q_valid_i && ((step_r == ST_IDLE) || (emit && is_last));

    if (take) begin
      step_nxt = start;
    end else if (emit) begin
      step_nxt = is_last ? ST_IDLE : after;
    end else begin
      step_nxt = step_r;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign q_pop_o = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_r <= q_job_i;
    end
    if (emit) begin
      out_char_r <= chr;
      out_last_r <= is_last;
      out_err_r  <= (step_r == ST_ERR);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tlast && (out_tdata == CHAR_NUL)))
    else $error("error beat is not a lone terminator");

  a_cr_then_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_CR && emit) |=> (step_r == ST_LF))
    else $error("line feed did not follow carriage return");

  a_pop_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop_o |-> ((step_r == ST_IDLE) || (emit && is_last)))
    else $error("job taken while another is in progress");

endmodule

`default_nettype wire

// File: bench/base64_line_encoder_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_line_encoder_chk
// Watches the configuration, input and output channels of the base64 line
// encoder. It keeps its own copy of the encoder state, works out the
// characters that each accepted input beat should produce and compares every
// output beat with the oldest character still owed.
// ----------------------------------------------------------------------------

module base64_line_encoder_chk (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wen,
  input  logic [9:0] cfg_wdata,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic       out_tlast,
  input  logic       out_tuser,
  output int         fail_count,
  output int         pending
);
  import b64le_pkg::*;

  localparam logic [511:0] SYMBOLS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } char_beat_t;

  char_beat_t  owed_q[$];
  logic [9:0]  line_len;
  logic [15:0] held;
  logic [1:0]  fill;
  logic [7:0]  blocks;
  logic        started;
  int          errors = 0;

  assign fail_count = errors;

  task automatic report(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [7:0] symbol(input logic [5:0] idx);
    return SYMBOLS[8*(63-idx) +: 8];
  endfunction

  task automatic owe(input logic [7:0] c);
    owed_q.push_back('{c, 1'b0, 1'b0});
  endtask

  task automatic owe_block(input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2, input int unsigned len);
    logic [9:0] per_line;
    per_line = line_len >> 2;
    if (per_line != 10'd0 && started && {2'b00, blocks} >= per_line) begin
      owe(CHAR_CR);
      owe(CHAR_LF);
      blocks = 8'd0;
    end
    owe(symbol(b0[7:2]));
    owe(symbol({b0[1:0], b1[7:4]}));
    owe(len > 1 ? symbol({b1[3:0], b2[7:6]}) : CHAR_PAD);
    owe(len > 2 ? symbol(b2[5:0]) : CHAR_PAD);
    started = 1'b1;
    if (blocks != 8'hFF) begin
      blocks++;
    end
  endtask

  task automatic encode_beat(input logic [7:0] data, input logic no_data,
                             input logic fin);
    int base;
    base = owed_q.size();
    if (line_len >= 10'd1 && line_len <= 10'd3) begin
      owed_q.push_back('{CHAR_NUL, 1'b1, 1'b1});
      return;
    end
    if (!no_data) begin
      case (fill)
        2'd0: begin
          held = {data, 8'h00};
          fill = 2'd1;
        end
        2'd1: begin
          held[7:0] = data;
          fill = 2'd2;
        end
        default: begin
          owe_block(held[15:8], held[7:0], data, 3);
          held = 16'h0000;
          fill = 2'd0;
        end
      endcase
    end
    if (fin) begin
      if (fill != 2'd0) begin
        owe_block(held[15:8], fill >= 2'd2 ? held[7:0] : 8'h00, 8'h00,
                  fill >= 2'd2 ? 2 : 1);
      end
      owe(CHAR_NUL);
      held = 16'h0000;
      fill = 2'd0;
      blocks = 8'd0;
      started = 1'b0;
    end
    if (owed_q.size() > base) begin
      owed_q[owed_q.size()-1].last = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    char_beat_t want;
    if (!rst_n) begin
      owed_q.delete();
      line_len = LINE_LEN_RST;
      held = 16'h0000;
      fill = 2'd0;
      blocks = 8'd0;
      started = 1'b0;
    end else begin
      if (cfg_wen) begin
        line_len = cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        if (owed_q.size() == 0) begin
          report($sformatf("output beat 0x%02h with no character owed", out_tdata));
        end else begin
          want = owed_q.pop_front();
          if (out_tdata !== want.ch) begin
            report($sformatf("char 0x%02h, expected 0x%02h", out_tdata, want.ch));
          end
          if (out_tlast !== want.last) begin
            report($sformatf("tlast %b, expected %b", out_tlast, want.last));
          end
          if (out_tuser !== want.err) begin
            report($sformatf("config error %b, expected %b", out_tuser, want.err));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        encode_beat(in_tdata, in_tuser, in_tlast);
      end
    end
    pending = owed_q.size();
  end

endmodule

// File: bench/base64_line_encoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_line_encoder_top_tb
// Drives messages into the base64 line encoder under several line sizes and
// stall patterns: a directed opening covers padding, empty messages, line
// breaks, invalid line sizes and a line size changed inside a message, then
// random messages follow. A separate checker predicts and compares the
// output characters; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------

module base64_line_encoder_top_tb;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wen = 1'b0;
  logic [9:0] cfg_wdata = 10'd0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tuser = 1'b0;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  int fail_count;
  int pending;
  int tx_idle = 0;
  int rx_idle = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int beat_count = 0;

  always #10 clk = ~clk;

  base64_line_encoder_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  base64_line_encoder_chk i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("base64_line_encoder_top verification failed");
          $finish;
        end
      end
    end
  end

  task automatic send_beat(input logic [7:0] data, input logic no_data,
                           input logic fin);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= no_data;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    beat_count++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (10) @(negedge clk);
  endtask

  task automatic set_line(input logic [9:0] len);
    settle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_wen   <= 1'b0;
  endtask

  task automatic send_message(input int unsigned n_bytes);
    logic close_on_byte;
    close_on_byte = (n_bytes > 0) && ($urandom_range(1) == 1);
    for (int unsigned i = 0; i < n_bytes; i++) begin
      if ($urandom_range(99) < 10) begin
        send_beat(8'($urandom_range(255)), 1'b1, 1'b0);
      end
      send_beat(8'($urandom_range(255)), 1'b0, close_on_byte && (i == n_bytes - 1));
    end
    if (!close_on_byte) begin
      send_beat(8'($urandom_range(255)), 1'b1, 1'b1);
    end
  endtask

  function automatic logic [9:0] pick_line();
    case ($urandom_range(9))
      0:       return 10'd0;
      1:       return 10'd1023;
      2:       return 10'd4;
      3:       return 10'd8;
      4:       return 10'd76;
      5:       return 10'($urandom_range(1, 3));
      6:       return 10'($urandom_range(5, 15));
      default: return 10'($urandom_range(4, 64));
    endcase
  endfunction

  task automatic run_phase(input int tx_pct, input int rx_pct, input int beats);
    int target;
    tx_idle = tx_pct;
    rx_idle = rx_pct;
    target = beat_count + beats;
    while (beat_count < target) begin
      if ($urandom_range(3) == 0) begin
        set_line(pick_line());
      end
      send_message($urandom_range(9) == 0 ? $urandom_range(20, 45) : $urandom_range(0, 10));
    end
  endtask

  initial begin
    tx_idle = 15;
    rx_idle = 79;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_beat(8'($urandom_range(255)), 1'b1, 1'b1);
    send_beat(8'hFF, 1'b0, 1'b1);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b1);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hA5, 1'b0, 1'b1);
    send_beat(8'h3C, 1'b0, 1'b0);
    send_beat(8'($urandom_range(255)), 1'b1, 1'b0);
    send_beat(8'hC3, 1'b0, 1'b0);
    send_beat(8'($urandom_range(255)), 1'b1, 1'b1);

    set_line(10'd4);
    for (int i = 0; i < 7; i++) begin
      send_beat(8'($urandom_range(255)), 1'b0, i == 6);
    end

    send_beat(8'h5A, 1'b0, 1'b0);
    send_beat(8'h81, 1'b0, 1'b0);
    set_line(10'd2);
    send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
    send_beat(8'($urandom_range(255)), 1'b1, 1'b1);
    set_line(10'd0);
    send_beat(8'h7E, 1'b0, 1'b1);

    set_line(10'd8);
    tx_idle = 15;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    @(negedge clk);
    send_message(24);
    settle();

    run_phase(15, 79, 15);
    run_phase(79, 15, 15);
    run_phase(0, 0, 15);

    settle();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("base64_line_encoder_top verification clean");
    end else begin
      $display("base64_line_encoder_top verification failed");
    end
    $finish;
  end

endmodule

// File: base64_line_encoder_top.f
sv/b64le_pkg.sv
sv/b64le_front.sv
sv/b64le_queue.sv
sv/b64le_back.sv
sv/base64_line_encoder_top.sv
bench/base64_line_encoder_chk.sv
bench/base64_line_encoder_top_tb.sv
